// ===== rtl/bqsc_pkg.sv =====
// Shared types, constants and constant tables for the balanced base-5 summing converter.
// Used by every module under rtl; depends on nothing else.
package bqsc_pkg;

	localparam int VALUE_WIDTH = 64;
	localparam int MAX_DIGITS = 28;
	localparam int CODE_W = 3;
	localparam int IDX_W = $clog2(MAX_DIGITS);
	localparam int POW_BITS = (MAX_DIGITS * 7 + 2) / 3 + 1;
	localparam int ACC_W = (POW_BITS > VALUE_WIDTH + 2) ? POW_BITS : VALUE_WIDTH + 2;

	localparam logic [CODE_W-1:0] CODE_ZERO = 3'd2;
	localparam logic [CODE_W-1:0] CODE_MAX = 3'd4;

	typedef struct packed {
		logic [CODE_W-1:0] digit_code;
		logic              last_of_number;
		logic              last_of_list;
	} in_req_t;

	typedef struct packed {
		logic [CODE_W-1:0] out_digit_code;
		logic              last_digit;
		logic              total_empty;
	} out_req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FOLD,
		ST_LOAD,
		ST_CONV,
		ST_ZERO
	} state_t;

	typedef struct packed {
		logic take;
		logic clear;
	} acc_ctl_t;

	typedef struct packed {
		logic load;
		logic next;
	} conv_ctl_t;

	typedef struct packed {
		logic              ready;
		logic [CODE_W-1:0] digit;
		logic              last;
	} conv_sts_t;

	typedef logic [ACC_W-1:0] pow_tab_t [MAX_DIGITS];

	function automatic pow_tab_t pow5_table();
		pow_tab_t         t;
		logic [ACC_W-1:0] p;
		p = ACC_W'(1);
		for (int i = 0; i < MAX_DIGITS; i++) begin
			t[i] = p;
			p = (p << 2) + p;
		end
		return t;
	endfunction

	// Adding a digit 2 at every position maps balanced digits onto plain base-5 digits.
	function automatic logic [ACC_W-1:0] offset_value();
		logic [ACC_W-1:0] p;
		logic [ACC_W-1:0] s;
		p = ACC_W'(1);
		s = '0;
		for (int i = 0; i < MAX_DIGITS; i++) begin
			s = s + (p << 1);
			p = (p << 2) + p;
		end
		return s;
	endfunction

	localparam pow_tab_t POW5 = pow5_table();
	localparam logic [ACC_W-1:0] OFFSET = offset_value();

endpackage

// ===== rtl/bqsc_accum.sv =====
// Digit accumulator: running number and running total, both wrapping at the value width.
// Depends on bqsc_pkg.
module bqsc_accum (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bqsc_pkg::acc_ctl_t             ctl,
	input  bqsc_pkg::in_req_t              req,
	output logic [bqsc_pkg::VALUE_WIDTH-1:0] total
);

	logic [bqsc_pkg::VALUE_WIDTH-1:0] cur_q;
	logic [bqsc_pkg::VALUE_WIDTH-1:0] pend_q;
	logic                             pend_v_q;
	logic [bqsc_pkg::VALUE_WIDTH-1:0] total_q;
	logic [bqsc_pkg::CODE_W-1:0]      dval;
	logic [bqsc_pkg::VALUE_WIDTH-1:0] cur_next;
	logic                             num_end;

	always_comb begin
		dval = (req.digit_code > bqsc_pkg::CODE_MAX) ? '0 : req.digit_code - bqsc_pkg::CODE_ZERO;
		cur_next = (cur_q << 2) + cur_q
			+ {{(bqsc_pkg::VALUE_WIDTH - bqsc_pkg::CODE_W){dval[bqsc_pkg::CODE_W-1]}}, dval};
		num_end = req.last_of_number | req.last_of_list;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
			pend_v_q <= 1'b0;
			total_q <= '0;
		end else begin
			if (ctl.clear) begin
				total_q <= '0;
			end else if (pend_v_q) begin
				total_q <= total_q + pend_q;
			end
			pend_v_q <= ctl.take & num_end;
			if (ctl.take) begin
				cur_q <= num_end ? '0 : cur_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take && num_end) begin
			pend_q <= cur_next;
		end
	end

	assign total = total_q;

endmodule

// ===== rtl/bqsc_conv.sv =====
// Digit extractor: one shared compare-and-subtract unit walks the powers of five downward.
// Depends on bqsc_pkg for the power table and the offset constant.
module bqsc_conv (
	input  logic                             clk,
	input  logic                             arst_n,
	input  bqsc_pkg::conv_ctl_t              ctl,
	input  logic [bqsc_pkg::VALUE_WIDTH-1:0] total,
	output bqsc_pkg::conv_sts_t              sts
);

	logic [bqsc_pkg::ACC_W-1:0]  rem_q;
	logic [bqsc_pkg::CODE_W-1:0] dig_q;
	logic [bqsc_pkg::IDX_W-1:0]  k_q;
	logic [bqsc_pkg::ACC_W:0]    diff;
	logic [bqsc_pkg::ACC_W-1:0]  pw;
	logic                        ge;

	always_comb begin
		pw = bqsc_pkg::POW5[k_q];
		diff = {1'b0, rem_q} - {1'b0, pw};
		ge = ~diff[bqsc_pkg::ACC_W];
		sts.ready = ~ge;
		sts.digit = dig_q;
		sts.last = (k_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
			dig_q <= '0;
		end else if (ctl.load) begin
			k_q <= bqsc_pkg::IDX_W'(bqsc_pkg::MAX_DIGITS - 1);
			dig_q <= '0;
		end else if (ge) begin
			dig_q <= dig_q + 1'b1;
		end else if (ctl.next) begin
			k_q <= k_q - 1'b1;
			dig_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rem_q <= {{(bqsc_pkg::ACC_W - bqsc_pkg::VALUE_WIDTH){total[bqsc_pkg::VALUE_WIDTH-1]}},
				total} + bqsc_pkg::OFFSET;
		end else if (ge) begin
			rem_q <= diff[bqsc_pkg::ACC_W-1:0];
		end
	end

endmodule

// ===== rtl/balanced_quinary_sum_converter.sv =====
// Top level of the balanced base-5 summing converter: sequencer and output register.
// Depends on bqsc_pkg, bqsc_accum and bqsc_conv.
// Digits are taken one per cycle while idle; a list-ending digit starts the conversion.
// The conversion first settles the total in the fold and load states, then compare-subtract
// steps find each of the 28 digit positions in turn; output stalls can hold it up.
// Reset clears the number, the total, the sequencer and the output valid.
module balanced_quinary_sum_converter (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               digit_valid,
	output logic               digit_stall,
	input  bqsc_pkg::in_req_t  digit_req,
	output logic               sum_valid,
	input  logic               sum_stall,
	output bqsc_pkg::out_req_t sum_req
);

	bqsc_pkg::state_t                 state_q;
	bqsc_pkg::state_t                 state_next;
	bqsc_pkg::acc_ctl_t               acc_ctl;
	bqsc_pkg::conv_ctl_t              conv_ctl;
	bqsc_pkg::conv_sts_t              conv_sts;
	logic [bqsc_pkg::VALUE_WIDTH-1:0] total;
	logic                             started_q;
	logic                             started_next;
	logic                             out_valid_q;
	bqsc_pkg::out_req_t               out_q;
	logic                             out_load;
	bqsc_pkg::out_req_t               out_next;
	logic                             slot_free;
	logic                             emit_want;

	bqsc_accum u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (acc_ctl),
		.req    (digit_req),
		.total  (total)
	);

	bqsc_conv u_conv (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (conv_ctl),
		.total  (total),
		.sts    (conv_sts)
	);

	assign slot_free = ~out_valid_q | ~sum_stall;
	assign digit_stall = (state_q != bqsc_pkg::ST_IDLE);

	always_comb begin
		state_next = state_q;
		started_next = started_q;
		acc_ctl = '0;
		conv_ctl = '0;
		out_load = 1'b0;
		out_next = '0;
		emit_want = conv_sts.ready
			& (started_q | (conv_sts.digit != bqsc_pkg::CODE_ZERO) | conv_sts.last);
		case (state_q)
			bqsc_pkg::ST_IDLE: begin
				acc_ctl.take = digit_valid;
				if (digit_valid && digit_req.last_of_list) begin
					state_next = bqsc_pkg::ST_FOLD;
				end
			end
			bqsc_pkg::ST_FOLD: begin
				state_next = bqsc_pkg::ST_LOAD;
			end
			bqsc_pkg::ST_LOAD: begin
				acc_ctl.clear = 1'b1;
				conv_ctl.load = 1'b1;
				started_next = 1'b0;
				state_next = (total == '0) ? bqsc_pkg::ST_ZERO : bqsc_pkg::ST_CONV;
			end
			bqsc_pkg::ST_CONV: begin
				if (conv_sts.ready && (!emit_want || slot_free)) begin
					conv_ctl.next = 1'b1;
					if (emit_want) begin
						out_load = 1'b1;
						started_next = 1'b1;
						out_next.out_digit_code = conv_sts.digit;
						out_next.last_digit = conv_sts.last;
					end
					if (conv_sts.last) begin
						state_next = bqsc_pkg::ST_IDLE;
					end
				end
			end
			bqsc_pkg::ST_ZERO: begin
				if (slot_free) begin
					out_load = 1'b1;
					out_next.out_digit_code = bqsc_pkg::CODE_ZERO;
					out_next.last_digit = 1'b1;
					out_next.total_empty = 1'b1;
					state_next = bqsc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = bqsc_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bqsc_pkg::ST_IDLE;
			started_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			started_q <= started_next;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!sum_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= out_next;
		end
	end

	assign sum_valid = out_valid_q;
	assign sum_req = out_q;

endmodule

// ===== rtl/bqsc_checker.sv =====
// Port-level checker for the balanced base-5 summing converter, bound to the top level.
// Depends on bqsc_pkg and balanced_quinary_sum_converter.
module bqsc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               digit_valid,
	input logic               digit_stall,
	input bqsc_pkg::in_req_t  digit_req,
	input logic               sum_valid,
	input logic               sum_stall,
	input bqsc_pkg::out_req_t sum_req
);

	a_list_end_busy: assert property (@(posedge clk) disable iff (!arst_n)
		digit_valid && !digit_stall && digit_req.last_of_list |=> digit_stall)
		else $error("A list-ending request did not start the conversion.");

	a_digit_keeps_ready: assert property (@(posedge clk) disable iff (!arst_n)
		digit_valid && !digit_stall && !digit_req.last_of_list |=> !digit_stall)
		else $error("The block became busy without a list end.");

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		sum_valid && sum_req.total_empty |-> sum_req.last_digit
			&& (sum_req.out_digit_code == bqsc_pkg::CODE_ZERO))
		else $error("An empty total was not a single zero digit.");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		sum_valid |-> sum_req.out_digit_code <= bqsc_pkg::CODE_MAX)
		else $error("An output digit code is out of range.");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		sum_valid && sum_stall |=> sum_valid && $stable(sum_req))
		else $error("A stalled output request changed.");

endmodule

bind balanced_quinary_sum_converter bqsc_checker u_bqsc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.digit_valid (digit_valid),
	.digit_stall (digit_stall),
	.digit_req   (digit_req),
	.sum_valid   (sum_valid),
	.sum_stall   (sum_stall),
	.sum_req     (sum_req)
);
